### rtl/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared types, constants and helpers for the axis-angle vector rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

    // square root steps: one result bit per stage, operand below 2^52
    localparam int SQ_STEPS  = 27;
    // quotient bits of each normalised axis component (Q.30, at most 2^30)
    localparam int DIV_STEPS = 31;
    // length of the arctangent table
    localparam int ATAN_LEN  = 24;

    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
    localparam logic signed [63:0] HALF_ULP    = 64'sd536870912;

    // front stage and square root pipeline payload
    typedef struct packed {
        logic [2:0][15:0]   vec;
        logic [2:0][15:0]   amag;
        logic [2:0]         aneg;
        logic               zero;
        logic [51:0]        sq_v;
        logic [52:0]        sq_res;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               flip;
    } sq_stage_t;

    // divider pipeline payload
    typedef struct packed {
        logic [2:0][15:0]   vec;
        logic [2:0]         aneg;
        logic               zero;
        logic [26:0]        root;
        logic [2:0][27:0]   rem;
        logic [2:0][30:0]   quo;
        logic signed [31:0] cosv;
        logic signed [31:0] sinv;
    } div_stage_t;

    // arctangent of 2^-i in Q.30
    function automatic logic signed [31:0] atan_q30(input int unsigned i);
        logic signed [31:0] r;
        case (i)
            0:       r = 32'sh3243F6A8;
            1:       r = 32'sh1DAC6705;
            2:       r = 32'sh0FADBAFC;
            3:       r = 32'sh07F56EA6;
            4:       r = 32'sh03FEAB76;
            5:       r = 32'sh01FFD55B;
            6:       r = 32'sh00FFFAAA;
            7:       r = 32'sh007FFF55;
            8:       r = 32'sh003FFFEA;
            9:       r = 32'sh001FFFFD;
            10:      r = 32'sh000FFFFF;
            11:      r = 32'sh0007FFFF;
            12:      r = 32'sh0003FFFF;
            13:      r = 32'sh0001FFFF;
            14:      r = 32'sh0000FFFF;
            15:      r = 32'sh00007FFF;
            16:      r = 32'sh00003FFF;
            17:      r = 32'sh00001FFF;
            18:      r = 32'sh00000FFF;
            19:      r = 32'sh000007FF;
            20:      r = 32'sh000003FF;
            21:      r = 32'sh000001FF;
            22:      r = 32'sh000000FF;
            23:      r = 32'sh0000007F;
            default: r = 32'sh00000000;
        endcase
        return r;
    endfunction

    // Q.30 product back to the operand scale, rounded half up
    function automatic logic signed [63:0] unit_back(input logic signed [63:0] v);
        return (v + HALF_ULP) >>> 30;
    endfunction

endpackage

### rtl/axis_angle_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_unit
// Rotates a Q4.12 vector about an arbitrary axis by a Q3.13 angle using
// Rodrigues' formula: normalise axis, CORDIC sine/cosine, then products.
// ----------------------------------------------------------------------------
//  channel | signals                                  | beat
//  input   | in_valid in_ready vec_* axis_* angle     | one vector, axis, angle
//  output  | out_valid out_ready rot_x rot_y rot_z    | one rotated vector
//
//  One beat per cycle unless the spare output entry is full; 64 pipeline
//  stages and the output register, mainly set by the 27-step square root and 31-step divider.
//  Reset clears only the valid bits; no clearing pass.
//  Output has a spare entry: a stalled result does not block the input until
//  that entry fills, then the whole pipeline holds in place.
module axis_angle_vector_rotate_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] vec_x,
    input  logic signed [15:0] vec_y,
    input  logic signed [15:0] vec_z,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [15:0] angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] rot_x,
    output logic signed [15:0] rot_y,
    output logic signed [15:0] rot_z
);
    import aavr_pkg::*;

    localparam int C0   = SQ_STEPS + 1;
    localparam int D0   = C0 + DIV_STEPS;
    localparam int NSTG = D0 + 5;

    typedef struct packed {
        logic [2:0][15:0]   vec;
        logic [2:0][31:0]   k;
        logic [2:0][2:0][47:0] p;
        logic signed [31:0] cosv;
        logic signed [31:0] sinv;
    } d1_t;

    typedef struct packed {
        logic [2:0][15:0]   vec;
        logic [2:0][31:0]   k;
        logic [2:0][19:0]   cr;
        logic signed [19:0] dot;
        logic signed [31:0] cosv;
        logic signed [31:0] sinv;
    } d2_t;

    typedef struct packed {
        logic [2:0][31:0]   k;
        logic signed [55:0] sclp;
        logic [2:0][47:0]   vc;
        logic [2:0][51:0]   crs;
    } d3_t;

    typedef struct packed {
        logic [2:0][31:0]   k;
        logic signed [23:0] scl;
        logic [2:0][47:0]   vc;
        logic [2:0][51:0]   crs;
    } d4_t;

    typedef struct packed {
        logic [2:0][47:0]   vc;
        logic [2:0][51:0]   crs;
        logic [2:0][55:0]   ks;
    } d5_t;

    logic [NSTG-1:0]  vld_reg;
    logic             en;
    sq_stage_t        b_reg [0:SQ_STEPS];
    div_stage_t       c_reg [0:DIV_STEPS-1];
    sq_stage_t        a_next;
    div_stage_t       c_conv;
    d1_t              d1_reg, d1_next;
    d2_t              d2_reg, d2_next;
    d3_t              d3_reg, d3_next;
    d4_t              d4_reg, d4_next;
    d5_t              d5_reg, d5_next;
    logic [2:0][15:0] res_now;
    logic [2:0][15:0] out_data_reg;
    logic [2:0][15:0] skid_data_reg;
    logic             out_vld_reg;
    logic             skid_vld_reg;

    // whole pipeline moves unless the spare output entry is occupied
    assign en       = ~skid_vld_reg;
    assign in_ready = en;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // front stage: axis squares, magnitudes, angle range fold
    always_comb
    begin
        logic signed [31:0] sq0, sq1, sq2;
        logic [31:0]        sumsq;
        logic signed [33:0] zraw;
        logic signed [33:0] zadj;
        sq0   = axis_x * axis_x;
        sq1   = axis_y * axis_y;
        sq2   = axis_z * axis_z;
        sumsq = sq0 + sq1 + sq2;
        a_next.vec    = {vec_z, vec_y, vec_x};
        a_next.aneg   = {axis_z[15], axis_y[15], axis_x[15]};
        a_next.amag[0] = axis_x[15] ? 16'(-axis_x) : axis_x;
        a_next.amag[1] = axis_y[15] ? 16'(-axis_y) : axis_y;
        a_next.amag[2] = axis_z[15] ? 16'(-axis_z) : axis_z;
        a_next.zero   = (sumsq == 32'd0);
        a_next.sq_v   = {sumsq, 20'd0};
        a_next.sq_res = '0;
        a_next.cx     = GAIN_Q30;
        a_next.cy     = '0;
        zraw = 34'(angle) <<< 17;
        a_next.flip = 1'b0;
        zadj = zraw;
        if (zraw > HALF_PI_Q30)
        begin
            zadj = zraw - PI_Q30;
            a_next.flip = 1'b1;
        end
        else if (zraw < -HALF_PI_Q30)
        begin
            zadj = zraw + PI_Q30;
            a_next.flip = 1'b1;
        end
        a_next.cz = 32'(zadj);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg[0] <= a_next;
        end
    end

    // square root, one bit a stage; CORDIC rides along in the first stages
    for (genvar gi = 0; gi < SQ_STEPS; gi++)
    begin : g_sqrt
        localparam logic [52:0] SQ_BIT = 53'(1) << (52 - 2 * gi);
        sq_stage_t   cur, nxt;
        logic [52:0] trial;

        always_comb
        begin
            cur   = b_reg[gi];
            nxt   = cur;
            trial = cur.sq_res + SQ_BIT;
            if ({1'b0, cur.sq_v} >= trial)
            begin
                nxt.sq_v   = cur.sq_v - trial[51:0];
                nxt.sq_res = (cur.sq_res >> 1) + SQ_BIT;
            end
            else
            begin
                nxt.sq_res = cur.sq_res >> 1;
            end
            if (gi < CORDIC_STAGES)
            begin
                if (cur.cz >= 0)
                begin
                    nxt.cx = cur.cx - (cur.cy >>> gi);
                    nxt.cy = cur.cy + (cur.cx >>> gi);
                    nxt.cz = cur.cz - atan_q30(gi);
                end
                else
                begin
                    nxt.cx = cur.cx + (cur.cy >>> gi);
                    nxt.cy = cur.cy - (cur.cx >>> gi);
                    nxt.cz = cur.cz + atan_q30(gi);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                b_reg[gi+1] <= nxt;
            end
        end
    end

    // divider entry: root, first partial remainders, signed sine/cosine
    always_comb
    begin
        c_conv.vec  = b_reg[SQ_STEPS].vec;
        c_conv.aneg = b_reg[SQ_STEPS].aneg;
        c_conv.zero = b_reg[SQ_STEPS].zero;
        c_conv.root = b_reg[SQ_STEPS].sq_res[26:0];
        for (int l = 0; l < 3; l++)
        begin
            c_conv.rem[l] = {3'd0, b_reg[SQ_STEPS].amag[l], 9'd0};
        end
        c_conv.quo  = '0;
        c_conv.cosv = b_reg[SQ_STEPS].flip ? -b_reg[SQ_STEPS].cx : b_reg[SQ_STEPS].cx;
        c_conv.sinv = b_reg[SQ_STEPS].flip ? -b_reg[SQ_STEPS].cy : b_reg[SQ_STEPS].cy;
    end

    // restoring division, one quotient bit a stage on all three lanes
    for (genvar gj = 0; gj < DIV_STEPS; gj++)
    begin : g_div
        div_stage_t cur, nxt;

        if (gj == 0)
        begin : g_first
            assign cur = c_conv;
        end
        else
        begin : g_rest
            assign cur = c_reg[gj-1];
        end

        always_comb
        begin
            logic [27:0] r2;
            nxt = cur;
            for (int l = 0; l < 3; l++)
            begin
                r2 = {cur.rem[l][26:0], 1'b0};
                if (r2 >= {1'b0, cur.root})
                begin
                    nxt.rem[l] = r2 - {1'b0, cur.root};
                    nxt.quo[l] = {cur.quo[l][29:0], 1'b1};
                end
                else
                begin
                    nxt.rem[l] = r2;
                    nxt.quo[l] = {cur.quo[l][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_reg[gj] <= nxt;
            end
        end
    end

    // signed unit axis and the nine axis-by-vector products
    always_comb
    begin
        logic signed [31:0] kk [3];
        logic signed [31:0] qs;
        for (int l = 0; l < 3; l++)
        begin
            qs = signed'({1'b0, c_reg[DIV_STEPS-1].quo[l]});
            if (c_reg[DIV_STEPS-1].zero)
            begin
                kk[l] = '0;
            end
            else
            begin
                kk[l] = c_reg[DIV_STEPS-1].aneg[l] ? -qs : qs;
            end
            d1_next.k[l] = kk[l];
        end
        for (int l = 0; l < 3; l++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                d1_next.p[l][m] = 48'(kk[l]) * 48'(signed'(c_reg[DIV_STEPS-1].vec[m]));
            end
        end
        d1_next.vec  = c_reg[DIV_STEPS-1].vec;
        d1_next.cosv = c_reg[DIV_STEPS-1].cosv;
        d1_next.sinv = c_reg[DIV_STEPS-1].sinv;
    end

    // cross product and dot product, brought back to vector scale
    always_comb
    begin
        logic signed [63:0] pp [3][3];
        for (int l = 0; l < 3; l++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                pp[l][m] = 64'(signed'(d1_reg.p[l][m]));
            end
        end
        d2_next.vec   = d1_reg.vec;
        d2_next.k     = d1_reg.k;
        d2_next.cosv  = d1_reg.cosv;
        d2_next.sinv  = d1_reg.sinv;
        d2_next.cr[0] = 20'(unit_back(pp[1][2] - pp[2][1]));
        d2_next.cr[1] = 20'(unit_back(pp[2][0] - pp[0][2]));
        d2_next.cr[2] = 20'(unit_back(pp[0][1] - pp[1][0]));
        d2_next.dot   = 20'(unit_back(pp[0][0] + pp[1][1] + pp[2][2]));
    end

    // dot times (1 - cos), v times cos, cross times sin
    always_comb
    begin
        logic signed [32:0] omc;
        omc = ONE_Q30 - 33'(d2_reg.cosv);
        d3_next.k    = d2_reg.k;
        d3_next.sclp = 56'(d2_reg.dot) * 56'(omc);
        for (int l = 0; l < 3; l++)
        begin
            d3_next.vc[l]  = 48'(signed'(d2_reg.vec[l])) * 48'(d2_reg.cosv);
            d3_next.crs[l] = 52'(signed'(d2_reg.cr[l])) * 52'(d2_reg.sinv);
        end
    end

    always_comb
    begin
        d4_next.k   = d3_reg.k;
        d4_next.vc  = d3_reg.vc;
        d4_next.crs = d3_reg.crs;
        d4_next.scl = 24'(unit_back(64'(d3_reg.sclp)));
    end

    // axis times scaled dot
    always_comb
    begin
        d5_next.vc  = d4_reg.vc;
        d5_next.crs = d4_reg.crs;
        for (int l = 0; l < 3; l++)
        begin
            d5_next.ks[l] = 56'(signed'(d4_reg.k[l])) * 56'(d4_reg.scl);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            d3_reg <= d3_next;
            d4_reg <= d4_next;
            d5_reg <= d5_next;
        end
    end

    // final sum, rounding and saturation
    always_comb
    begin
        logic signed [63:0] sum;
        logic signed [63:0] u;
        for (int l = 0; l < 3; l++)
        begin
            sum = 64'(signed'(d5_reg.vc[l])) + 64'(signed'(d5_reg.crs[l]))
                + 64'(signed'(d5_reg.ks[l]));
            u = unit_back(sum);
            if (u > 64'sd32767)
            begin
                res_now[l] = 16'h7FFF;
            end
            else if (u < -64'sd32768)
            begin
                res_now[l] = 16'h8000;
            end
            else
            begin
                res_now[l] = u[15:0];
            end
        end
    end

    // output register with one spare entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_vld_reg && !out_ready)
        begin
            if (en && vld_reg[NSTG-1])
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (skid_vld_reg)
        begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_vld_reg && !out_ready)
        begin
            if (en && vld_reg[NSTG-1])
            begin
                skid_data_reg <= res_now;
            end
        end
        else if (skid_vld_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else
        begin
            out_data_reg <= res_now;
        end
    end

    assign out_valid = out_vld_reg;
    assign rot_x     = out_data_reg[0];
    assign rot_y     = out_data_reg[1];
    assign rot_z     = out_data_reg[2];

endmodule

### rtl/aavr_checker.sv
// ----------------------------------------------------------------------------
// aavr_checker
// Port-level checks for the axis-angle vector rotator, bound to the top level.
// ----------------------------------------------------------------------------
module aavr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] rot_x,
    input logic signed [15:0] rot_y,
    input logic signed [15:0] rot_z
);

    // an empty output means the spare entry is free too
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held off with no result pending");

    // a full spare entry stays full while the result is stalled
    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !in_ready |=> !in_ready)
        else $error("spare entry emptied during output stall");

    // stalled output beat stays valid
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // stalled output beat keeps its payload
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z))
        else $error("output payload changed while stalled");

endmodule

bind axis_angle_vector_rotate_unit aavr_checker u_aavr_checker (.*);
